[hw/rtl/ngtr_pkg.sv]
// Package: shared types, constants and address helper for the nested-grid resampler.
`default_nettype none
package ngtr_pkg;
  localparam int PARENT_R  = 32;
  localparam int PARENT_TH = 32;
  localparam int PARENT_Z  = 32;
  localparam int NEST_MAX  = 64;
  localparam int GRID_SIZE = PARENT_R * PARENT_TH * PARENT_Z;
  localparam int AW        = $clog2(GRID_SIZE);

  // multiplier operand and product widths
  localparam int MA_W = 33;
  localparam int MB_W = 24;
  localparam int MP_W = MA_W + MB_W;

  localparam logic [1:0] FUNC_LOAD     = 2'd0;
  localparam logic [1:0] FUNC_INTERP   = 2'd1;
  localparam logic [1:0] FUNC_FEEDBACK = 2'd2;
  localparam logic [1:0] FUNC_READ     = 2'd3;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_DISABLED = 2'd1;
  localparam logic [1:0] ST_OUTSIDE  = 2'd2;

  localparam logic [2:0] REG_ENABLED = 3'd0;
  localparam logic [2:0] REG_INV     = 3'd1;
  localparam logic [2:0] REG_CTR_R   = 3'd2;
  localparam logic [2:0] REG_CTR_TH  = 3'd3;
  localparam logic [2:0] REG_CTR_Z   = 3'd4;
  localparam logic [2:0] REG_NEST_R  = 3'd5;
  localparam logic [2:0] REG_NEST_TH = 3'd6;
  localparam logic [2:0] REG_NEST_Z  = 3'd7;

  typedef struct packed {
    logic [1:0]         func;
    logic [5:0]         index_r;
    logic [5:0]         index_th;
    logic [5:0]         index_z;
    logic signed [31:0] sample_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } out_word_t;

  // linear address of a parent cell, row-major r, th, z
  function automatic logic [AW-1:0] grid_addr(input logic [8:0] r, input logic [8:0] t,
                                              input logic [8:0] z);
    logic [31:0] a;
    a = ({23'd0, r} * 32'(PARENT_TH) + {23'd0, t}) * 32'(PARENT_Z) + {23'd0, z};
    return a[AW-1:0];
  endfunction
endpackage
`default_nettype wire

[hw/rtl/ngtr_mul.sv]
// Shared registered signed multiplier used for coordinates and blend steps.
`default_nettype none
module ngtr_mul (
  input  wire logic                                clk,
  input  wire logic signed [ngtr_pkg::MA_W-1:0]   a,
  input  wire logic signed [ngtr_pkg::MB_W-1:0]   b,
  output logic signed      [ngtr_pkg::MP_W-1:0]   prod
);
  always_ff @(posedge clk) begin
    prod <= ngtr_pkg::MP_W'(a) * ngtr_pkg::MP_W'(b);
  end
endmodule
`default_nettype wire

[hw/rtl/nested_grid_trilinear_resampler_top.sv]
// Top level: nested-grid trilinear resampler with parent field memory and sequencer.
//
// Holds one 32x32x32 parent field of Q20.12 words in a single-port-write,
// one-read memory and serves one input word at a time (in_ready is high only
// when the sequencer is idle). A load, a disabled request or an out-of-range
// parent access passes through idle, decode and done, and an in-range read adds
// one memory-read state. A feedback write runs one multiply and one axis step
// per axis, then the write. An interpolation computes the three coordinates,
// makes the eight corner reads through the one memory read port, and then runs
// the seven blend steps, each one pass through the shared multiplier. The done
// cycle stretches while an earlier result word is still unaccepted. The result
// word waits in an output register, so a new input word may be taken while it
// is still pending. Parent entries have no reset; reading an entry never written
// returns whatever the memory holds. Configuration writes take effect at once
// and should only be issued while the block is idle.
`default_nettype none
module nested_grid_trilinear_resampler_top (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ngtr_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ngtr_pkg::out_word_t      out_word,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [12:0]         cfg_data
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_AX   = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_CAP  = 4'd5;
  localparam logic [3:0] S_LA   = 4'd6;
  localparam logic [3:0] S_LM   = 4'd7;
  localparam logic [3:0] S_LW   = 4'd8;
  localparam logic [3:0] S_FBW  = 4'd9;
  localparam logic [3:0] S_P3   = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  localparam int AW   = ngtr_pkg::AW;
  localparam int MA_W = ngtr_pkg::MA_W;
  localparam int MB_W = ngtr_pkg::MB_W;
  localparam int MP_W = ngtr_pkg::MP_W;

  // configuration
  logic        enabled;
  logic [12:0] inv;
  logic [4:0]  ctr_r, ctr_th, ctr_z;
  logic [6:0]  nest_r, nest_th, nest_z;

  // sequencer
  logic [3:0]          state;
  ngtr_pkg::in_word_t  item;
  logic [1:0]          ax;
  logic [2:0]          k;
  logic [2:0]          lstep;
  logic signed [31:0]  res;
  logic [1:0]          res_st;

  // per-axis results
  logic [7:0]          base_r, base_th, base_z;
  logic signed [23:0]  f_r, f_th, f_z;
  logic [2:0]          in_grid;

  // corner values and blend operands
  logic signed [31:0]    vals [8];
  logic signed [31:0]    a_reg;
  logic signed [MA_W-1:0] d_reg;
  logic signed [MB_W-1:0] f_reg;

  // memory
  logic [31:0]   mem [ngtr_pkg::GRID_SIZE];
  logic [31:0]   mem_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          mem_we;

  // multiplier
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] prod;

  ngtr_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  // axis selection
  logic [4:0]         ax_ctr;
  logic [5:0]         ax_idx;
  logic [6:0]         ax_size;
  logic signed [10:0] ax_dim;
  always_comb begin
    case (ax)
      2'd0: begin
        ax_ctr = ctr_r; ax_idx = item.index_r; ax_size = nest_r;
        ax_dim = 11'(ngtr_pkg::PARENT_R);
      end
      2'd1: begin
        ax_ctr = ctr_th; ax_idx = item.index_th; ax_size = nest_th;
        ax_dim = 11'(ngtr_pkg::PARENT_TH);
      end
      default: begin
        ax_ctr = ctr_z; ax_idx = item.index_z; ax_size = nest_z;
        ax_dim = 11'(ngtr_pkg::PARENT_Z);
      end
    endcase
  end

  // (2*index - size) as 9-bit signed
  logic signed [8:0] ax_diff;
  assign ax_diff = $signed({2'b00, ax_idx, 1'b0}) - $signed({2'b00, ax_size});

  assign mul_a = (state == S_LM) ? d_reg : MA_W'(ax_diff);
  assign mul_b = (state == S_LM) ? f_reg : $signed({11'd0, inv});

  // interpolate axis: coordinate, clamped base and weight
  logic signed [23:0] coord;
  logic signed [10:0] base_raw;
  logic [7:0]         base_cl;
  logic signed [23:0] f_new;
  always_comb begin
    coord    = $signed({6'd0, ax_ctr, 13'd0}) + prod[23:0];
    base_raw = coord[23:13];
    if (base_raw < 11'sd0) base_cl = 8'd0;
    else if (base_raw > ax_dim - 11'sd2) base_cl = 8'(ax_dim - 11'sd2);
    else base_cl = base_raw[7:0];
    f_new = coord - $signed({3'd0, base_cl, 13'd0});
  end

  // feedback axis: rounded offset, half away from zero
  logic signed [23:0] off;
  logic [23:0]        mag;
  logic [10:0]        q_rnd;
  logic signed [12:0] pos;
  logic               pos_in;
  always_comb begin
    off    = prod[23:0];
    mag    = off[23] ? 24'(-off) : off;
    q_rnd  = 11'((mag + 24'd4096) >> 13);
    pos    = off[23] ? $signed({8'd0, ax_ctr}) - $signed({2'd0, q_rnd})
                     : $signed({8'd0, ax_ctr}) + $signed({2'd0, q_rnd});
    pos_in = (pos >= 13'sd0) && (pos < 13'(ax_dim));
  end

  // blend step operands
  logic [1:0]         pair;
  logic signed [31:0] la, lb;
  logic signed [MB_W-1:0] lf;
  always_comb begin
    if (lstep < 3'd4) begin
      pair = lstep[1:0]; lf = f_z;
    end else if (lstep < 3'd6) begin
      pair = 2'(lstep - 3'd4); lf = f_th;
    end else begin
      pair = 2'd0; lf = f_r;
    end
    la = vals[{pair, 1'b0}];
    lb = vals[{pair, 1'b1}];
  end

  // blend finish: a + ((b-a)*f + half) >> 13, saturated
  logic signed [MP_W-1:0] lq;
  logic signed [MP_W:0]   lsum;
  logic signed [31:0]     lsat;
  always_comb begin
    lq   = (prod + MP_W'(4096)) >>> 13;
    lsum = (MP_W+1)'(a_reg) + (MP_W+1)'(lq);
    if (lsum > (MP_W+1)'(32'sh7fffffff)) lsat = 32'sh7fffffff;
    else if (lsum < -(MP_W+1)'(33'sh80000000)) lsat = 32'sh80000000;
    else lsat = lsum[31:0];
  end

  // direct parent address for load/read
  logic item_in;
  assign item_in = ({3'd0, item.index_r}  < 9'(ngtr_pkg::PARENT_R))  &&
                   ({3'd0, item.index_th} < 9'(ngtr_pkg::PARENT_TH)) &&
                   ({3'd0, item.index_z}  < 9'(ngtr_pkg::PARENT_Z));

  always_comb begin
    if (state == S_DEC)
      rd_addr = ngtr_pkg::grid_addr({3'd0, item.index_r}, {3'd0, item.index_th},
                                    {3'd0, item.index_z});
    else
      rd_addr = ngtr_pkg::grid_addr({1'b0, base_r} + {8'd0, k[2]},
                                    {1'b0, base_th} + {8'd0, k[1]},
                                    {1'b0, base_z} + {8'd0, k[0]});
  end

  always_comb begin
    if (state == S_FBW)
      wr_addr = ngtr_pkg::grid_addr({1'b0, base_r}, {1'b0, base_th}, {1'b0, base_z});
    else
      wr_addr = ngtr_pkg::grid_addr({3'd0, item.index_r}, {3'd0, item.index_th},
                                    {3'd0, item.index_z});
  end

  assign mem_we = ((state == S_DEC) && (item.func == ngtr_pkg::FUNC_LOAD) && item_in) ||
                  ((state == S_FBW) && (in_grid == 3'b111));

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= item.sample_value;
    mem_q <= mem[rd_addr];
  end

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
      inv     <= 13'd2048;
      ctr_r   <= 5'd16; ctr_th <= 5'd16; ctr_z <= 5'd16;
      nest_r  <= 7'd32; nest_th <= 7'd32; nest_z <= 7'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        ngtr_pkg::REG_ENABLED: enabled <= cfg_data[0];
        ngtr_pkg::REG_INV:     inv     <= cfg_data;
        ngtr_pkg::REG_CTR_R:   ctr_r   <= cfg_data[4:0];
        ngtr_pkg::REG_CTR_TH:  ctr_th  <= cfg_data[4:0];
        ngtr_pkg::REG_CTR_Z:   ctr_z   <= cfg_data[4:0];
        ngtr_pkg::REG_NEST_R:  nest_r  <= cfg_data[6:0];
        ngtr_pkg::REG_NEST_TH: nest_th <= cfg_data[6:0];
        ngtr_pkg::REG_NEST_Z:  nest_z  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  // payload registers of the sequencer
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (in_valid) item <= in_word;
      S_DEC: begin
        res <= 32'sd0;
        res_st <= ngtr_pkg::ST_DONE;
        ax <= 2'd0;
        k <= 3'd0;
        lstep <= 3'd0;
        if (item.func == ngtr_pkg::FUNC_LOAD || item.func == ngtr_pkg::FUNC_READ) begin
          if (!item_in) res_st <= ngtr_pkg::ST_OUTSIDE;
        end else if (!enabled) begin
          res_st <= ngtr_pkg::ST_DISABLED;
        end
      end
      S_P3: res <= mem_q;
      S_AX: begin
        ax <= ax + 2'd1;
        if (item.func == ngtr_pkg::FUNC_INTERP) begin
          case (ax)
            2'd0: begin base_r <= base_cl; f_r <= f_new; end
            2'd1: begin base_th <= base_cl; f_th <= f_new; end
            default: begin base_z <= base_cl; f_z <= f_new; end
          endcase
        end else begin
          in_grid[ax] <= pos_in;
          case (ax)
            2'd0: base_r <= pos[7:0];
            2'd1: base_th <= pos[7:0];
            default: base_z <= pos[7:0];
          endcase
        end
      end
      S_CAP: begin
        vals[k] <= mem_q;
        k <= k + 3'd1;
      end
      S_LA: begin
        a_reg <= la;
        d_reg <= MA_W'(lb) - MA_W'(la);
        f_reg <= lf;
      end
      S_LW: begin
        vals[{1'b0, pair}] <= lsat;
        lstep <= lstep + 3'd1;
        if (lstep == 3'd6) res <= lsat;
      end
      S_FBW: if (in_grid != 3'b111) res_st <= ngtr_pkg::ST_OUTSIDE;
      default: ;
    endcase
  end

  // control state
  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) state <= S_DEC;
        S_DEC: begin
          if (item.func == ngtr_pkg::FUNC_LOAD) state <= S_DONE;
          else if (item.func == ngtr_pkg::FUNC_READ) state <= item_in ? S_P3 : S_DONE;
          else if (!enabled) state <= S_DONE;
          else state <= S_MUL;
        end
        S_P3: state <= S_DONE;
        S_MUL: state <= S_AX;
        S_AX: begin
          if (ax != 2'd2) state <= S_MUL;
          else if (item.func == ngtr_pkg::FUNC_INTERP) state <= S_RD;
          else state <= S_FBW;
        end
        S_RD: state <= S_CAP;
        S_CAP: state <= (k == 3'd7) ? S_LA : S_RD;
        S_LA: state <= S_LM;
        S_LM: state <= S_LW;
        S_LW: state <= (lstep == 3'd6) ? S_DONE : S_LA;
        S_FBW: state <= S_DONE;
        S_DONE: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_word.result_value <= (res_st == ngtr_pkg::ST_DONE) ? res : 32'sd0;
      out_word.status       <= res_st;
    end
  end

  // checks
  a_out_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.status != 2'd3))
    else $error("status code out of range");
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_DEC || state == S_FBW))
    else $error("memory write outside a write step");
  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (out_valid && state == S_IDLE))
    else $error("result word not presented");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DEC))
    else $error("accepted word not decoded");
endmodule
`default_nettype wire
